// ===== rtl/x86mov_pkg.sv =====
// ----------------------------------------------------------------------------
// x86mov_pkg
// Shared types and constants for the x86-64 MOV byte encoder.
// ----------------------------------------------------------------------------
package x86mov_pkg;

	// field widths
	localparam int CMD_W  = 3;
	localparam int REG_W  = 3;
	localparam int DISP_W = 8;
	localparam int IMM_W  = 32;
	localparam int BYTE_W = 8;

	// longest encoding in bytes, and the index width over it
	localparam int MAX_BYTES = 7;
	localparam int IDX_W     = $clog2(MAX_BYTES);

	// front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// request forms
	typedef enum logic [CMD_W-1:0] {
		CMD_R32_IMM = 3'd0,
		CMD_R64_R64 = 3'd1,
		CMD_MEM_IMM = 3'd2,
		CMD_MEM_R32 = 3'd3,
		CMD_R32_MEM = 3'd4,
		CMD_R64_MEM = 3'd5
	} cmd_e_t;

	// opcode and prefix bytes
	localparam logic [BYTE_W-1:0] OP_MOV_RI   = 8'hB8;
	localparam logic [BYTE_W-1:0] PFX_REX_W   = 8'h48;
	localparam logic [BYTE_W-1:0] OP_MOV_RM_R = 8'h89;
	localparam logic [BYTE_W-1:0] OP_MOV_M_I  = 8'hC7;
	localparam logic [BYTE_W-1:0] OP_MOV_R_RM = 8'h8B;

	// ModRM mod fields
	localparam logic [1:0] MOD_DISP8 = 2'b01;
	localparam logic [1:0] MOD_REG   = 2'b11;

	// register number that needs a SIB byte as a base
	localparam logic [REG_W-1:0] REG_RSP = 3'd4;

	// one decoded instruction: bytes in emit order, index of the final byte, RSP-base error flag
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [IDX_W-1:0]                 last_idx;
		logic                             base_err;
	} enc_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/x86mov_req_if.sv =====
// ----------------------------------------------------------------------------
// x86mov_req_if
// Request channel: one MOV request word per handshake.
// ----------------------------------------------------------------------------
interface x86mov_req_if
	import x86mov_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [REG_W-1:0]         dest_reg;
	logic [REG_W-1:0]         src_reg;
	logic signed [DISP_W-1:0] displacement;
	logic signed [IMM_W-1:0]  immediate;

	modport source (output valid, cmd, dest_reg, src_reg, displacement, immediate,
		input ready);
	modport sink (input valid, cmd, dest_reg, src_reg, displacement, immediate,
		output ready);
endinterface

// ===== rtl/x86mov_byte_if.sv =====
// ----------------------------------------------------------------------------
// x86mov_byte_if
// Result channel: one machine-code byte word per handshake.
// ----------------------------------------------------------------------------
interface x86mov_byte_if
	import x86mov_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;
	logic              base_error;

	modport source (output valid, out_byte, last_byte, base_error, input ready);
	modport sink (input valid, out_byte, last_byte, base_error, output ready);
endinterface

// ===== rtl/x86mov_front.sv =====
// ----------------------------------------------------------------------------
// x86mov_front
// Accepts requests, classifies the form and builds the full byte sequence.
// ----------------------------------------------------------------------------
module x86mov_front
	import x86mov_pkg::*;
(
	x86mov_req_if.sink req,
	input  q_stat_t    q_stat,
	output logic       push,
	output enc_t       push_data
);

	logic             form_ok;
	logic             is_mem;
	logic [REG_W-1:0] base;
	logic [7:0]       disp_b;
	enc_t             enc;

	assign disp_b = req.displacement;

	// form decode and byte build
	always_comb begin
		enc     = '0;
		form_ok = 1'b1;
		is_mem  = 1'b0;
		base    = req.src_reg;
		unique case (cmd_e_t'(req.cmd))
			CMD_R32_IMM: begin
				enc.bytes[0] = OP_MOV_RI | {5'd0, req.dest_reg};
				enc.bytes[1] = req.immediate[7:0];
				enc.bytes[2] = req.immediate[15:8];
				enc.bytes[3] = req.immediate[23:16];
				enc.bytes[4] = req.immediate[31:24];
				enc.last_idx = IDX_W'(4);
			end
			CMD_R64_R64: begin
				enc.bytes[0] = PFX_REX_W;
				enc.bytes[1] = OP_MOV_RM_R;
				enc.bytes[2] = {MOD_REG, req.src_reg, req.dest_reg};
				enc.last_idx = IDX_W'(2);
			end
			CMD_MEM_IMM: begin
				is_mem       = 1'b1;
				base         = req.dest_reg;
				enc.bytes[0] = OP_MOV_M_I;
				enc.bytes[1] = {MOD_DISP8, 3'd0, req.dest_reg};
				enc.bytes[2] = disp_b;
				enc.bytes[3] = req.immediate[7:0];
				enc.bytes[4] = req.immediate[15:8];
				enc.bytes[5] = req.immediate[23:16];
				enc.bytes[6] = req.immediate[31:24];
				enc.last_idx = IDX_W'(6);
			end
			CMD_MEM_R32: begin
				is_mem       = 1'b1;
				base         = req.dest_reg;
				enc.bytes[0] = OP_MOV_RM_R;
				enc.bytes[1] = {MOD_DISP8, req.src_reg, req.dest_reg};
				enc.bytes[2] = disp_b;
				enc.last_idx = IDX_W'(2);
			end
			CMD_R32_MEM: begin
				is_mem       = 1'b1;
				enc.bytes[0] = OP_MOV_R_RM;
				enc.bytes[1] = {MOD_DISP8, req.dest_reg, req.src_reg};
				enc.bytes[2] = disp_b;
				enc.last_idx = IDX_W'(2);
			end
			CMD_R64_MEM: begin
				is_mem       = 1'b1;
				enc.bytes[0] = PFX_REX_W;
				enc.bytes[1] = OP_MOV_R_RM;
				enc.bytes[2] = {MOD_DISP8, req.dest_reg, req.src_reg};
				enc.bytes[3] = disp_b;
				enc.last_idx = IDX_W'(3);
			end
			default: begin
				form_ok = 1'b0;
			end
		endcase
		// RSP base has no SIB support: single zero byte, flagged
		if (is_mem && base == REG_RSP) begin
			enc          = '0;
			enc.base_err = 1'b1;
		end
	end

	// unused selectors are taken and dropped
	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full && form_ok;
	assign push_data = enc;

endmodule

// ===== rtl/x86mov_queue.sv =====
// ----------------------------------------------------------------------------
// x86mov_queue
// Short FIFO of decoded instructions between the front and the back.
// ----------------------------------------------------------------------------
module x86mov_queue
	import x86mov_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  enc_t    push_data,
	input  logic    pop,
	output enc_t    head,
	output q_stat_t q_stat
);

	enc_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/x86mov_back.sv =====
// ----------------------------------------------------------------------------
// x86mov_back
// Walks the head instruction one byte per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module x86mov_back
	import x86mov_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  enc_t          head,
	input  q_stat_t       q_stat,
	output logic          pop,
	x86mov_byte_if.source rsp
);

	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              err_q;
	logic              load;
	logic              at_last;

	// output register free or draining this cycle, and the queue holds an instruction
	assign load    = !q_stat.empty && (!valid_q || rsp.ready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? '0 : idx_q + 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_last;
			err_q  <= head.base_err;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.out_byte   = byte_q;
	assign rsp.last_byte  = last_q;
	assign rsp.base_error = err_q;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && err_q |-> last_q && byte_q == '0)
		else $error("error word not a single zero byte");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> idx_q <= head.last_idx)
		else $error("byte index past end of instruction");
	a_mid_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !q_stat.empty)
		else $error("instruction lost mid-emission");

endmodule

// ===== rtl/x86mov_encoder_top.sv =====
// ----------------------------------------------------------------------------
// x86_mov_encoder_top
// x86-64 MOV encoder: one request in, its machine-code bytes out in order.
// ----------------------------------------------------------------------------
// Channel | Dir | Word
// req     | in  | cmd, dest_reg, src_reg, displacement, immediate
// rsp     | out | out_byte, last_byte, base_error
//
// The front decodes a request in the cycle it is taken; the back emits one
// byte per cycle from the queue head while the output is not stalled, so
// the instruction length in bytes (1 to 7) sets the sustained rate.
// A two-entry queue lets requests be taken while bytes are still going out.
// Reset clears the queue and the output valid; no clearing pass is needed.
// Output stalls hold the byte register and back up into the queue.
// ----------------------------------------------------------------------------
module x86_mov_encoder_top
	import x86mov_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	x86mov_req_if.sink    req,
	x86mov_byte_if.source rsp
);

	logic    push;
	enc_t    push_data;
	logic    pop;
	enc_t    head;
	q_stat_t q_stat;

	x86mov_front u_front (
		.req       (req),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	x86mov_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	x86mov_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ===== bench/x86_mov_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_mov_encoder_top_tb
// Self-checking bench for the x86-64 MOV byte encoder.
// Drives MOV requests of every form and register/displacement/immediate
// corner, predicts the machine-code bytes of each accepted request, and
// checks every output byte, last marker and RSP-base flag in order.
// Both channels idle and stall at random, with one stall-free burst and
// pauses that let the encoder drain completely.
// ----------------------------------------------------------------------------
module x86_mov_encoder_top_tb
	import x86mov_pkg::*;
	;

	// selector values outside the six forms; the encoder ignores them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int IDLE_PCT     = 38;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYC   = 20;
	localparam int MAX_REPORTS  = 10;

	// one expected machine-code byte
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
		logic              err;
	} mc_byte_t;

	logic clk;
	logic arst_n;

	x86mov_req_if  req_ch ();
	x86mov_byte_if rsp_ch ();

	x86_mov_encoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mc_byte_t bytes_due[$];
	bit       req_gaps_on;
	bit       rsp_stalls_on;
	int       mismatches;
	int       bytes_checked;
	int       rsp_rejects;
	int       form_cnt[8];
	int       idle_cycles;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// work out the bytes of one request and queue them
	function automatic void encode_mov(input logic [CMD_W-1:0] cmd,
		input logic [REG_W-1:0] dst, input logic [REG_W-1:0] src,
		input logic [DISP_W-1:0] disp, input logic [IMM_W-1:0] imm);
		logic [BYTE_W-1:0] enc[$];
		logic [REG_W-1:0]  base;
		mc_byte_t          b;
		if (cmd > CMD_R64_MEM)
			return;
		base = (cmd == CMD_MEM_IMM || cmd == CMD_MEM_R32) ? dst : src;
		// no SIB support: RSP as base yields one flagged zero byte
		if (cmd >= CMD_MEM_IMM && base == REG_RSP) begin
			b.value = '0;
			b.last  = 1'b1;
			b.err   = 1'b1;
			bytes_due.push_back(b);
			return;
		end
		case (cmd)
			CMD_R32_IMM: begin
				enc.push_back(OP_MOV_RI + dst);
			end
			CMD_R64_R64: begin
				enc.push_back(PFX_REX_W);
				enc.push_back(OP_MOV_RM_R);
				enc.push_back({MOD_REG, src, dst});
			end
			CMD_MEM_IMM: begin
				enc.push_back(OP_MOV_M_I);
				enc.push_back({MOD_DISP8, 3'd0, dst});
				enc.push_back(disp);
			end
			CMD_MEM_R32: begin
				enc.push_back(OP_MOV_RM_R);
				enc.push_back({MOD_DISP8, src, dst});
				enc.push_back(disp);
			end
			CMD_R32_MEM: begin
				enc.push_back(OP_MOV_R_RM);
				enc.push_back({MOD_DISP8, dst, src});
				enc.push_back(disp);
			end
			default: begin
				enc.push_back(PFX_REX_W);
				enc.push_back(OP_MOV_R_RM);
				enc.push_back({MOD_DISP8, dst, src});
				enc.push_back(disp);
			end
		endcase
		// imm32, little endian
		if (cmd == CMD_R32_IMM || cmd == CMD_MEM_IMM) begin
			enc.push_back(imm[7:0]);
			enc.push_back(imm[15:8]);
			enc.push_back(imm[23:16]);
			enc.push_back(imm[31:24]);
		end
		foreach (enc[i]) begin
			b.value = enc[i];
			b.last  = (i == enc.size() - 1);
			b.err   = 1'b0;
			bytes_due.push_back(b);
		end
	endfunction

	// send one request word; valid stays high afterwards for a back-to-back word
	task automatic send_mov(input logic [CMD_W-1:0] cmd, input logic [REG_W-1:0] dst,
		input logic [REG_W-1:0] src, input logic [DISP_W-1:0] disp,
		input logic [IMM_W-1:0] imm);
		while (req_gaps_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= cmd;
		req_ch.dest_reg     <= dst;
		req_ch.src_reg      <= src;
		req_ch.displacement <= disp;
		req_ch.immediate    <= imm;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		encode_mov(cmd, dst, src, disp, imm);
		form_cnt[cmd]++;
	endtask

	// random request: mostly real forms, a few spare selectors
	task automatic send_random_mov(output bit real_form);
		logic [CMD_W-1:0] cmd;
		logic [IMM_W-1:0] imm;
		if ($urandom_range(99) < 5)
			cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		else
			cmd = CMD_W'($urandom_range(CMD_R64_MEM));
		case ($urandom_range(9))
			0: imm = 32'h0000_0000;
			1: imm = 32'hFFFF_FFFF;
			2: imm = 32'h7FFF_FFFF;
			3: imm = 32'h8000_0000;
			default: imm = $urandom;
		endcase
		send_mov(cmd, REG_W'($urandom_range(7)), REG_W'($urandom_range(7)),
			DISP_W'($urandom_range(255)), imm);
		real_form = (cmd <= CMD_R64_MEM);
	endtask

	// hold off the sender until every queued byte has come out
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
	endtask

	// corners of every form, RSP as base, RSP in non-base slots, spare selectors
	task automatic test_directed();
		req_gaps_on   = 1'b1;
		rsp_stalls_on = 1'b1;
		send_mov(CMD_R32_IMM, 3'd0, 3'd0, 8'h00, 32'h0000_0000);
		send_mov(CMD_R32_IMM, 3'd7, 3'd3, 8'h11, 32'h7FFF_FFFF);
		send_mov(CMD_R32_IMM, 3'd4, 3'd4, 8'h80, 32'h8000_0000);
		send_mov(CMD_R32_IMM, 3'd3, 3'd7, 8'h7F, 32'hFFFF_FFFF);
		send_mov(CMD_R64_R64, 3'd0, 3'd7, 8'h00, 32'h1234_5678);
		send_mov(CMD_R64_R64, 3'd7, 3'd0, 8'hFF, 32'h0000_0000);
		send_mov(CMD_R64_R64, 3'd4, 3'd4, 8'h80, 32'hFFFF_FFFF);
		send_mov(CMD_MEM_IMM, 3'd0, 3'd5, 8'h80, 32'h1234_5678);
		send_mov(CMD_MEM_IMM, 3'd7, 3'd4, 8'h7F, 32'hFFFF_FFFF);
		send_mov(CMD_MEM_IMM, 3'd4, 3'd1, 8'h10, 32'hDEAD_BEEF);
		send_mov(CMD_MEM_R32, 3'd7, 3'd7, 8'h7F, 32'h0000_0000);
		send_mov(CMD_MEM_R32, 3'd0, 3'd4, 8'h80, 32'h0000_0000);
		send_mov(CMD_MEM_R32, 3'd4, 3'd2, 8'h01, 32'hFFFF_FFFF);
		send_mov(CMD_R32_MEM, 3'd7, 3'd0, 8'hFF, 32'h0000_0000);
		send_mov(CMD_R32_MEM, 3'd4, 3'd7, 8'h00, 32'h0000_0000);
		send_mov(CMD_R32_MEM, 3'd3, 3'd4, 8'h40, 32'h0000_0000);
		send_mov(CMD_R64_MEM, 3'd0, 3'd7, 8'h80, 32'h0000_0000);
		send_mov(CMD_R64_MEM, 3'd7, 3'd0, 8'h7F, 32'hFFFF_FFFF);
		send_mov(CMD_R64_MEM, 3'd2, 3'd4, 8'hC3, 32'h0000_0000);
		send_mov(CMD_SPARE_LO, 3'd4, 3'd4, 8'h80, 32'hFFFF_FFFF);
		send_mov(CMD_SPARE_HI, 3'd4, 3'd4, 8'h7F, 32'h0000_0000);
		send_mov(CMD_R32_IMM, 3'd5, 3'd0, 8'h00, 32'h0000_0001);
		send_mov(CMD_MEM_IMM, 3'd5, 3'd6, 8'h00, 32'h8000_0000);
	endtask

	// back-to-back requests with no gaps and no stalls
	task automatic test_burst(input int n);
		bit real_form;
		int sent;
		req_gaps_on   = 1'b0;
		rsp_stalls_on = 1'b0;
		sent = 0;
		while (sent < n) begin
			send_random_mov(real_form);
			if (real_form)
				sent++;
		end
	endtask

	// groups of requests, each followed by a full drain
	task automatic test_drain_pause(input int groups, input int per_group);
		bit real_form;
		int sent;
		req_gaps_on   = 1'b1;
		rsp_stalls_on = 1'b1;
		for (int g = 0; g < groups; g++) begin
			sent = 0;
			while (sent < per_group) begin
				send_random_mov(real_form);
				if (real_form)
					sent++;
			end
			wait_drained();
		end
	endtask

	// random requests with random gaps and stalls
	task automatic test_random(input int n);
		bit real_form;
		int sent;
		req_gaps_on   = 1'b1;
		rsp_stalls_on = 1'b1;
		sent = 0;
		while (sent < n) begin
			send_random_mov(real_form);
			if (real_form)
				sent++;
		end
	endtask

	// receiver: random stalls on the byte channel
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !(rsp_stalls_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	// check each byte word against the oldest expected byte
	always @(posedge clk) begin
		mc_byte_t exp_b;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected byte %02h last %0b err %0b", rsp_ch.out_byte,
						rsp_ch.last_byte, rsp_ch.base_error);
			end else begin
				exp_b = bytes_due.pop_front();
				bytes_checked++;
				if (rsp_ch.base_error)
					rsp_rejects++;
				if (rsp_ch.out_byte !== exp_b.value || rsp_ch.last_byte !== exp_b.last ||
					rsp_ch.base_error !== exp_b.err) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("byte mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
							exp_b.value, exp_b.last, exp_b.err, rsp_ch.out_byte,
							rsp_ch.last_byte, rsp_ch.base_error);
				end
			end
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = '0;
		req_ch.dest_reg     = '0;
		req_ch.src_reg      = '0;
		req_ch.displacement = '0;
		req_ch.immediate    = '0;
		req_gaps_on         = 1'b0;
		rsp_stalls_on       = 1'b0;
		mismatches          = 0;
		bytes_checked       = 0;
		rsp_rejects         = 0;
		idle_cycles         = 0;
		foreach (form_cnt[i])
			form_cnt[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_burst(40);
		test_drain_pause(2, 8);
		test_random(180);

		// drain, then let any ignored request settle
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);

		if (bytes_due.size() != 0)
			$display("%0d expected bytes never arrived", bytes_due.size());
		$display("requests per form 0..5: %0d/%0d/%0d/%0d/%0d/%0d, spare %0d",
			form_cnt[CMD_R32_IMM], form_cnt[CMD_R64_R64], form_cnt[CMD_MEM_IMM],
			form_cnt[CMD_MEM_R32], form_cnt[CMD_R32_MEM], form_cnt[CMD_R64_MEM],
			form_cnt[CMD_SPARE_LO] + form_cnt[CMD_SPARE_HI]);
		$display("bytes checked %0d, RSP-base rejections %0d, mismatches %0d",
			bytes_checked, rsp_rejects, mismatches);
		if (mismatches == 0 && bytes_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
